>>> sv/sbsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsd_pkg
// Shared types, constants and round functions for the SHA-1 byte stream
// digest block.
// ----------------------------------------------------------------------------
package sbsd_pkg;

	// SHA-1 initial chaining values
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hefcdab89;
	localparam logic [31:0] H2_INIT = 32'h98badcfe;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

	// Round constants, one per group of twenty rounds
	localparam logic [31:0] K_GRP0 = 32'h5A827999;
	localparam logic [31:0] K_GRP1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_GRP2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_GRP3 = 32'hCA62C1D6;

	// Padding marker byte and the block positions that bound the length field
	localparam logic [7:0] PAD_MARK      = 8'h80;
	localparam logic [7:0] PAD_ZERO      = 8'h00;
	localparam logic [5:0] LEN_START     = 6'd56;
	localparam logic [5:0] LAST_POS      = 6'd63;
	localparam logic [6:0] LAST_ROUND    = 7'd79;
	localparam logic [2:0] LAST_WORD     = 3'd4;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	typedef enum logic [1:0] {
		GRP_CH  = 2'd0,
		GRP_PAR = 2'd1,
		GRP_MAJ = 2'd2,
		GRP_XOR = 2'd3
	} sbsd_grp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_OUT
	} sbsd_state_t;

	// Control from the sequencer to the window and the round unit
	typedef struct packed {
		logic       push;       // shift one byte into the block window
		logic [7:0] push_byte;
		logic       round_en;   // run one round
		sbsd_grp_t  grp;        // round group of the current round
		logic       load;       // copy chaining words into working words
		logic       add;        // fold working words into chaining words
		logic       init;       // restore initial chaining words
	} sbsd_ctl_t;

	function automatic logic [31:0] round_f(sbsd_grp_t grp, logic [31:0] b,
			logic [31:0] c, logic [31:0] d);
		logic [31:0] f;
		case (grp)
			GRP_CH:  f = d ^ (b & (c ^ d));
			GRP_MAJ: f = (b & c) | (d & (b | c));
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	function automatic logic [31:0] round_k(sbsd_grp_t grp);
		logic [31:0] k;
		case (grp)
			GRP_CH:  k = K_GRP0;
			GRP_PAR: k = K_GRP1;
			GRP_MAJ: k = K_GRP2;
			default: k = K_GRP3;
		endcase
		return k;
	endfunction

endpackage

>>> sv/sbsd_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsd_sched
// Block window and message schedule: collects bytes big-endian into a
// sixteen-word shift window, then advances the schedule one word per round.
// ----------------------------------------------------------------------------
module sbsd_sched
	import sbsd_pkg::*;
(
	input  logic        clk,
	input  sbsd_ctl_t   ctl,
	output logic [31:0] w_cur
);

	logic [31:0] w_q [16];
	logic [31:0] w_mix;
	logic [31:0] w_new;

	// Next schedule word from the window taps
	assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new = {w_mix[30:0], w_mix[31]};
	assign w_cur = w_q[0];

	// Shift in a byte, or advance the schedule by one word
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], ctl.push_byte};
		end else if (ctl.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
	end

endmodule

>>> sv/sbsd_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbsd_round
// Shared SHA-1 round unit: five working words updated once per cycle while rounds run, and
// the five chaining words that collect each block's result.
// ----------------------------------------------------------------------------
module sbsd_round
	import sbsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sbsd_ctl_t   ctl,
	input  logic [31:0] w_cur,
	input  logic [2:0]  word_sel,
	output logic [31:0] word_out
);

	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h_q [5];
	logic [31:0] t_sum;

	// One round: rotated a plus f, e, constant and schedule word
	assign t_sum = {a_q[26:0], a_q[31:27]} + round_f(ctl.grp, b_q, c_q, d_q) +
		e_q + round_k(ctl.grp) + w_cur;

	// Working words
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctl.round_en) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Chaining words: fold in a block result, or restore for a new message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= H0_INIT;
			h_q[1] <= H1_INIT;
			h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT;
			h_q[4] <= H4_INIT;
		end else if (ctl.init) begin
			h_q[0] <= H0_INIT;
			h_q[1] <= H1_INIT;
			h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT;
			h_q[4] <= H4_INIT;
		end else if (ctl.add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	// Select the digest word being sent
	always_comb begin
		case (word_sel)
			3'd0:    word_out = h_q[0];
			3'd1:    word_out = h_q[1];
			3'd2:    word_out = h_q[2];
			3'd3:    word_out = h_q[3];
			default: word_out = h_q[4];
		endcase
	end

endmodule

>>> sv/sha1_byte_stream_digest_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_digest_top
// SHA-1 digest over a byte stream with a sequencer around one round unit.
// ----------------------------------------------------------------------------
// A request carries one message byte (s_tuser high) and may close the message
// (s_tlast high). A request is taken while the block is idle. A byte that
// completes a 64-byte block starts 80 rounds of the shared round unit and one
// chaining add, which run before s_tready returns. A closing request then pads
// one byte per cycle (0x80, zeros, the 64-bit big-endian bit count) and
// compresses one or two more blocks, after which the five digest words leave
// on the master side, word 0 first, word 4 with m_tlast. The block takes no
// request until the last word has been taken, and then starts the next
// message from the initial chaining values.
// ----------------------------------------------------------------------------
module sha1_byte_stream_digest_top
	import sbsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] data_byte
	input  logic        s_tuser,    // [0] byte_present
	input  logic        s_tlast,    // message_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] digest_word
	output logic [2:0]  m_tuser,    // [2:0] word_number
	output logic        m_tlast     // final_word
);

	sbsd_state_t state_q, state_d;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [6:0]  rnd_q;
	logic [2:0]  word_q;
	logic        end_q;
	logic        mark_q;
	logic        lenph_q;

	sbsd_ctl_t   ctl;
	logic [31:0] w_cur;
	logic        s_acc;
	logic        m_acc;
	logic        len_byte_sel;
	logic [2:0]  len_idx;
	logic [7:0]  pad_byte;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_acc    = m_tvalid && m_tready;
	assign m_tuser  = word_q;
	assign m_tlast  = (word_q == LAST_WORD);

	// Pick the padding byte: marker, zero, or a byte of the bit count
	assign len_byte_sel = lenph_q || (mark_q && (fill_q == LEN_START));
	assign len_idx      = ~fill_q[2:0];
	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_byte_sel) begin
			pad_byte = len_q[{len_idx, 3'b000} +: 8];
		end else begin
			pad_byte = PAD_ZERO;
		end
	end

	// Next state and control
	always_comb begin
		state_d       = state_q;
		ctl.push      = 1'b0;
		ctl.push_byte = pad_byte;
		ctl.round_en  = 1'b0;
		ctl.load      = 1'b0;
		ctl.add       = 1'b0;
		ctl.init      = 1'b0;
		if (rnd_q < 7'd20) begin
			ctl.grp = GRP_CH;
		end else if (rnd_q < 7'd40) begin
			ctl.grp = GRP_PAR;
		end else if (rnd_q < 7'd60) begin
			ctl.grp = GRP_MAJ;
		end else begin
			ctl.grp = GRP_XOR;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					ctl.push      = s_tuser;
					ctl.push_byte = s_tdata;
					if (s_tuser && (fill_q == LAST_POS)) begin
						ctl.load = 1'b1;
						state_d  = ST_COMP;
					end else if (s_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				ctl.push = 1'b1;
				if (fill_q == LAST_POS) begin
					ctl.load = 1'b1;
					state_d  = ST_COMP;
				end
			end
			ST_COMP: begin
				ctl.round_en = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				ctl.add = 1'b1;
				if (end_q && lenph_q) begin
					state_d = ST_OUT;
				end else if (end_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				if (m_acc && (word_q == LAST_WORD)) begin
					ctl.init = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Fill count, bit count, round and word counters, padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			len_q   <= '0;
			rnd_q   <= '0;
			word_q  <= '0;
			end_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenph_q <= 1'b0;
		end else begin
			if (ctl.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (s_acc) begin
				end_q <= s_tlast;
				if (s_tuser) begin
					len_q <= len_q + BITS_PER_BYTE;
				end
			end
			if (state_q == ST_PAD) begin
				mark_q <= 1'b1;
				if (len_byte_sel) begin
					lenph_q <= 1'b1;
				end
			end
			if (ctl.round_en) begin
				rnd_q <= rnd_q + 7'd1;
			end else if (ctl.add) begin
				rnd_q <= '0;
			end
			// Advance the word index, or restart it once the last word is taken
			if (ctl.init) begin
				word_q <= '0;
			end else if (m_acc) begin
				word_q <= word_q + 3'd1;
			end
			if (ctl.init) begin
				len_q   <= '0;
				end_q   <= 1'b0;
				mark_q  <= 1'b0;
				lenph_q <= 1'b0;
			end
		end
	end

	sbsd_sched u_sched (
		.clk   (clk),
		.ctl   (ctl),
		.w_cur (w_cur)
	);

	sbsd_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.w_cur    (w_cur),
		.word_sel (word_q),
		.word_out (m_tdata)
	);

endmodule
